// ===== design/ppa_pkg.sv =====
// ----------------------------------------------------------------------------
// ppa_pkg - shared types and constants of the parallel port adapter
// Request and result beat layouts, request codes and control register fields.
// ----------------------------------------------------------------------------
`default_nettype none

package ppa_pkg;

	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_EVENT = 2'd2
	} req_kind_t;

	typedef enum logic [1:0] {
		OFS_DATA_A = 2'd0,
		OFS_CTRL_A = 2'd1,
		OFS_DATA_B = 2'd2,
		OFS_CTRL_B = 2'd3
	} reg_ofs_t;

	typedef enum logic [1:0] {
		LINE_SEL_CA1 = 2'd0,
		LINE_SEL_CA2 = 2'd1,
		LINE_SEL_CB1 = 2'd2,
		LINE_SEL_CB2 = 2'd3
	} line_sel_t;

	// control register fields
	localparam logic [7:0] MODE_MASK      = 8'h38;
	localparam logic [7:0] MODE_HANDSHAKE = 8'h20;
	localparam logic [7:0] MODE_MANUAL    = 8'h30;
	localparam logic [7:0] CLR_FLAG2      = 8'hBF;
	localparam logic [7:0] CLR_FLAG1      = 8'h7F;
	localparam int         BIT_IRQ1_EN    = 0;
	localparam int         BIT_SEL_OUT    = 2;
	localparam int         BIT_LINE2_CTL  = 3;
	localparam int         BIT_LINE2_OUT  = 5;
	localparam int         BIT_FLAG2      = 6;
	localparam int         BIT_FLAG1      = 7;

	// positions in the driven line vector
	localparam int         POS_CA2        = 1;
	localparam int         POS_CB2        = 3;

	typedef struct packed {
		req_kind_t   req_type;
		reg_ofs_t    reg_offset;
		logic [7:0]  write_data;
		line_sel_t   line_select;
	} req_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [7:0]  port_a_value;
		logic        port_a_written;
		logic [7:0]  port_b_value;
		logic        port_b_written;
		logic        irq_a;
		logic        irq_b;
		logic [3:0]  control_lines;
	} rsp_t;

endpackage

`default_nettype wire

// ===== design/ppa_stream_if.sv =====
// ----------------------------------------------------------------------------
// ppa_stream_if - valid/ready channel
// Carries one payload beat per handshake; source drives valid and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppa_stream_if #(
	parameter type payload_t = ppa_pkg::req_t
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/parallel_port_adapter.sv =====
// ----------------------------------------------------------------------------
// parallel_port_adapter - two-port parallel interface adapter
// Register file, handshake and interrupt logic of a two-port parallel adapter.
// ----------------------------------------------------------------------------
// Each request beat (bus read, bus write or control line transition) is
// decoded against the side A and side B register state in the cycle it is
// accepted; the state updates at that edge and the result beat is captured
// in the result register at the same edge. The request side is ready
// whenever the result register is empty or its beat is taken in the same
// cycle, so throughput is one item per clock while the result side takes
// its beats, bounded only by the single result register.
`default_nettype none

module parallel_port_adapter (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ppa_stream_if.sink  req,
	ppa_stream_if.source rsp
);

	logic [7:0] ctl_a_q, out_a_q, dir_a_q;
	logic [7:0] ctl_b_q, out_b_q, dir_b_q;
	logic [3:0] lines_q;

	logic [7:0] ctl_a_n, out_a_n, dir_a_n;
	logic [7:0] ctl_b_n, out_b_n, dir_b_n;
	logic [3:0] lines_n;

	logic        rsp_valid_q;
	ppa_pkg::rsp_t rsp_q;
	ppa_pkg::rsp_t rsp_n;

	logic accept;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	always_comb begin
		logic hs_a, hs_b;
		hs_a = (ctl_a_q & ppa_pkg::MODE_MASK) == ppa_pkg::MODE_HANDSHAKE;
		hs_b = (ctl_b_q & ppa_pkg::MODE_MASK) == ppa_pkg::MODE_HANDSHAKE;

		ctl_a_n = ctl_a_q;
		out_a_n = out_a_q;
		dir_a_n = dir_a_q;
		ctl_b_n = ctl_b_q;
		out_b_n = out_b_q;
		dir_b_n = dir_b_q;
		lines_n = lines_q;
		rsp_n   = '0;

		unique case (req.data.req_type)
			ppa_pkg::REQ_READ: begin
				unique case (req.data.reg_offset)
					ppa_pkg::OFS_DATA_A: begin
						if (ctl_a_q[ppa_pkg::BIT_SEL_OUT]) begin
							rsp_n.read_data = out_a_q;
							ctl_a_n = ctl_a_q & ppa_pkg::CLR_FLAG2 & ppa_pkg::CLR_FLAG1;
							// a port A read ends the CA2 handshake
							if (hs_a) lines_n[ppa_pkg::POS_CA2] = 1'b0;
						end else begin
							rsp_n.read_data = dir_a_q;
						end
					end
					ppa_pkg::OFS_CTRL_A: rsp_n.read_data = ctl_a_q;
					ppa_pkg::OFS_DATA_B: begin
						if (ctl_b_q[ppa_pkg::BIT_SEL_OUT]) begin
							rsp_n.read_data = out_b_q;
							ctl_b_n = ctl_b_q & ppa_pkg::CLR_FLAG2 & ppa_pkg::CLR_FLAG1;
						end else begin
							rsp_n.read_data = dir_b_q;
						end
					end
					ppa_pkg::OFS_CTRL_B: rsp_n.read_data = ctl_b_q;
					default: ;
				endcase
			end
			ppa_pkg::REQ_WRITE: begin
				unique case (req.data.reg_offset)
					ppa_pkg::OFS_DATA_A: begin
						if (ctl_a_q[ppa_pkg::BIT_SEL_OUT]) begin
							out_a_n = req.data.write_data & dir_a_q;
							rsp_n.port_a_written = 1'b1;
						end else begin
							dir_a_n = req.data.write_data;
						end
					end
					ppa_pkg::OFS_CTRL_A: begin
						ctl_a_n = req.data.write_data;
						if ((req.data.write_data & ppa_pkg::MODE_MANUAL) == ppa_pkg::MODE_MANUAL)
							lines_n[ppa_pkg::POS_CA2] =
								req.data.write_data[ppa_pkg::BIT_LINE2_CTL];
					end
					ppa_pkg::OFS_DATA_B: begin
						if (ctl_b_q[ppa_pkg::BIT_SEL_OUT]) begin
							out_b_n = req.data.write_data & dir_b_q;
							rsp_n.port_b_written = 1'b1;
							// a port B write ends the CB2 handshake
							if (hs_b) lines_n[ppa_pkg::POS_CB2] = 1'b0;
						end else begin
							dir_b_n = req.data.write_data;
						end
					end
					ppa_pkg::OFS_CTRL_B: begin
						ctl_b_n = req.data.write_data;
						if ((req.data.write_data & ppa_pkg::MODE_MANUAL) == ppa_pkg::MODE_MANUAL)
							lines_n[ppa_pkg::POS_CB2] =
								req.data.write_data[ppa_pkg::BIT_LINE2_CTL];
					end
					default: ;
				endcase
			end
			ppa_pkg::REQ_EVENT: begin
				unique case (req.data.line_select)
					ppa_pkg::LINE_SEL_CA1: begin
						ctl_a_n[ppa_pkg::BIT_FLAG1] = 1'b1;
						rsp_n.irq_a = ctl_a_q[ppa_pkg::BIT_IRQ1_EN];
						if (hs_a) lines_n[ppa_pkg::POS_CA2] = 1'b1;
					end
					ppa_pkg::LINE_SEL_CA2: begin
						ctl_a_n[ppa_pkg::BIT_FLAG2] = 1'b1;
						rsp_n.irq_a = !ctl_a_q[ppa_pkg::BIT_LINE2_OUT] &&
							ctl_a_q[ppa_pkg::BIT_LINE2_CTL];
					end
					ppa_pkg::LINE_SEL_CB1: begin
						ctl_b_n[ppa_pkg::BIT_FLAG1] = 1'b1;
						rsp_n.irq_b = ctl_b_q[ppa_pkg::BIT_IRQ1_EN];
						if (hs_b) lines_n[ppa_pkg::POS_CB2] = 1'b1;
					end
					ppa_pkg::LINE_SEL_CB2: begin
						ctl_b_n[ppa_pkg::BIT_FLAG2] = 1'b1;
						rsp_n.irq_b = !ctl_b_q[ppa_pkg::BIT_LINE2_OUT] &&
							ctl_b_q[ppa_pkg::BIT_LINE2_CTL];
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		rsp_n.port_a_value  = out_a_n;
		rsp_n.port_b_value  = out_b_n;
		rsp_n.control_lines = lines_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_a_q <= '0;
			out_a_q <= '0;
			dir_a_q <= '0;
			ctl_b_q <= '0;
			out_b_q <= '0;
			dir_b_q <= '0;
			lines_q <= '0;
		end else if (accept) begin
			ctl_a_q <= ctl_a_n;
			out_a_q <= out_a_n;
			dir_a_q <= dir_a_n;
			ctl_b_q <= ctl_b_n;
			out_b_q <= out_b_n;
			dir_b_q <= dir_b_n;
			lines_q <= lines_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) rsp_q <= rsp_n;
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// CA1/CB1 are inputs and never driven
	a_input_lines_undriven: assert property (@(posedge clk) disable iff (!arst_n)
		!lines_q[0] && !lines_q[2])
		else $error("CA1 or CB1 driven");

	// one event per beat, so the two sides never interrupt together
	a_irq_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.irq_a && rsp_q.irq_b))
		else $error("irq on both sides in one beat");

	a_accept_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q)
		else $error("accepted beat lost its result");

	a_read_data_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.data.req_type != ppa_pkg::REQ_READ) |=> rsp_q.read_data == 8'h00)
		else $error("read data on a non-read beat");

	a_written_excludes_irq: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_q.port_a_written || rsp_q.port_b_written))
			|-> !(rsp_q.irq_a || rsp_q.irq_b))
		else $error("port write and irq in one beat");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - regression bench of the parallel port adapter
// Drives bus reads, bus writes and control line transitions with random
// gaps, predicts every result beat from a register level model of both
// sides and compares each field of the result beats in order.
// ----------------------------------------------------------------------------

module tb;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int         NUM_ITEMS  = 1950;

	// ------------------------------------------------------------------
	// register model of both sides and the queue of expected result beats
	// ------------------------------------------------------------------
	class port_adapter_scoreboard;
		logic [7:0] ctl_a, out_a, ddr_a;
		logic [7:0] ctl_b, out_b, ddr_b;
		logic [3:0] lines;
		ppa_pkg::rsp_t expected_rsp[$];
		int         mismatch_cnt;

		function new();
			ctl_a = '0; out_a = '0; ddr_a = '0;
			ctl_b = '0; out_b = '0; ddr_b = '0;
			lines = '0;
			mismatch_cnt = 0;
		endfunction

		function void drive_manual(logic [7:0] ctl, int pos);
			if ((ctl & ppa_pkg::MODE_MANUAL) == ppa_pkg::MODE_MANUAL)
				lines[pos] = ctl[ppa_pkg::BIT_LINE2_CTL];
		endfunction

		function ppa_pkg::rsp_t predict(ppa_pkg::req_t r);
			ppa_pkg::rsp_t e;
			e = '0;
			case (r.req_type)
				ppa_pkg::REQ_READ: begin
					case (r.reg_offset)
						ppa_pkg::OFS_DATA_A: begin
							if (ctl_a[ppa_pkg::BIT_SEL_OUT]) begin
								e.read_data = out_a;
								ctl_a = ctl_a & ppa_pkg::CLR_FLAG2 & ppa_pkg::CLR_FLAG1;
								// a port A read ends the CA2 handshake
								if ((ctl_a & ppa_pkg::MODE_MASK) == ppa_pkg::MODE_HANDSHAKE)
									lines[ppa_pkg::POS_CA2] = 1'b0;
							end else begin
								e.read_data = ddr_a;
							end
						end
						ppa_pkg::OFS_CTRL_A: e.read_data = ctl_a;
						ppa_pkg::OFS_DATA_B: begin
							if (ctl_b[ppa_pkg::BIT_SEL_OUT]) begin
								e.read_data = out_b;
								ctl_b = ctl_b & ppa_pkg::CLR_FLAG2 & ppa_pkg::CLR_FLAG1;
							end else begin
								e.read_data = ddr_b;
							end
						end
						default: e.read_data = ctl_b;
					endcase
				end
				ppa_pkg::REQ_WRITE: begin
					case (r.reg_offset)
						ppa_pkg::OFS_DATA_A: begin
							if (ctl_a[ppa_pkg::BIT_SEL_OUT]) begin
								out_a = r.write_data & ddr_a;
								e.port_a_written = 1'b1;
							end else begin
								ddr_a = r.write_data;
							end
						end
						ppa_pkg::OFS_CTRL_A: begin
							ctl_a = r.write_data;
							drive_manual(ctl_a, ppa_pkg::POS_CA2);
						end
						ppa_pkg::OFS_DATA_B: begin
							if (ctl_b[ppa_pkg::BIT_SEL_OUT]) begin
								out_b = r.write_data & ddr_b;
								e.port_b_written = 1'b1;
								// only a port B write ends the CB2 handshake
								if ((ctl_b & ppa_pkg::MODE_MASK) == ppa_pkg::MODE_HANDSHAKE)
									lines[ppa_pkg::POS_CB2] = 1'b0;
							end else begin
								ddr_b = r.write_data;
							end
						end
						default: begin
							ctl_b = r.write_data;
							drive_manual(ctl_b, ppa_pkg::POS_CB2);
						end
					endcase
				end
				ppa_pkg::REQ_EVENT: begin
					case (r.line_select)
						ppa_pkg::LINE_SEL_CA1: begin
							ctl_a[ppa_pkg::BIT_FLAG1] = 1'b1;
							e.irq_a = ctl_a[ppa_pkg::BIT_IRQ1_EN];
							if ((ctl_a & ppa_pkg::MODE_MASK) == ppa_pkg::MODE_HANDSHAKE)
								lines[ppa_pkg::POS_CA2] = 1'b1;
						end
						ppa_pkg::LINE_SEL_CA2: begin
							ctl_a[ppa_pkg::BIT_FLAG2] = 1'b1;
							e.irq_a = !ctl_a[ppa_pkg::BIT_LINE2_OUT] &&
								ctl_a[ppa_pkg::BIT_LINE2_CTL];
						end
						ppa_pkg::LINE_SEL_CB1: begin
							ctl_b[ppa_pkg::BIT_FLAG1] = 1'b1;
							e.irq_b = ctl_b[ppa_pkg::BIT_IRQ1_EN];
							if ((ctl_b & ppa_pkg::MODE_MASK) == ppa_pkg::MODE_HANDSHAKE)
								lines[ppa_pkg::POS_CB2] = 1'b1;
						end
						default: begin
							ctl_b[ppa_pkg::BIT_FLAG2] = 1'b1;
							e.irq_b = !ctl_b[ppa_pkg::BIT_LINE2_OUT] &&
								ctl_b[ppa_pkg::BIT_LINE2_CTL];
						end
					endcase
				end
				default: ;
			endcase
			e.port_a_value  = out_a;
			e.port_b_value  = out_b;
			e.control_lines = lines;
			return e;
		endfunction

		function void note_request(ppa_pkg::req_t r);
			expected_rsp.push_back(predict(r));
		endfunction

		function void compare_field(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t mismatch on %s: expected %h, actual %h",
					$time, field, want, got);
				mismatch_cnt++;
			end
		endfunction

		function void check_result(ppa_pkg::rsp_t got);
			ppa_pkg::rsp_t want;
			if (expected_rsp.size() == 0) begin
				$display("%0t unexpected result beat: expected none, actual %h", $time, got);
				mismatch_cnt++;
				return;
			end
			want = expected_rsp.pop_front();
			compare_field("read_data", want.read_data, got.read_data);
			compare_field("port_a_value", want.port_a_value, got.port_a_value);
			compare_field("port_a_written", 8'(want.port_a_written),
				8'(got.port_a_written));
			compare_field("port_b_value", want.port_b_value, got.port_b_value);
			compare_field("port_b_written", 8'(want.port_b_written),
				8'(got.port_b_written));
			compare_field("irq_a", 8'(want.irq_a), 8'(got.irq_a));
			compare_field("irq_b", 8'(want.irq_b), 8'(got.irq_b));
			compare_field("control_lines", 8'(want.control_lines),
				8'(got.control_lines));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ppa_stream_if #(.payload_t(ppa_pkg::req_t)) req_ch ();
	ppa_stream_if #(.payload_t(ppa_pkg::rsp_t)) rsp_ch ();

	parallel_port_adapter i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	port_adapter_scoreboard sb;
	int sent_cnt;
	int req_calm;
	int rsp_calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly random gaps, with occasional stretches of back-to-back beats
	function automatic int draw_gap(ref int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			calm_left = $urandom_range(10, 40);
		return $urandom_range(0, 12);
	endfunction

	function automatic ppa_pkg::req_t make_req(logic [1:0] kind, logic [1:0] ofs,
			logic [7:0] wd, logic [1:0] line);
		return ppa_pkg::req_t'({kind, ofs, wd, line});
	endfunction

	function automatic logic [7:0] rand_ctl();
		logic [7:0] c;
		c = 8'($urandom);
		c[ppa_pkg::BIT_SEL_OUT] = ($urandom_range(0, 3) != 0);
		if ($urandom_range(0, 1) == 0)
			c = c & ppa_pkg::CLR_FLAG2 & ppa_pkg::CLR_FLAG1;
		return c;
	endfunction

	task automatic send_req(ppa_pkg::req_t r);
		int gap;
		gap = draw_gap(req_calm);
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
		end
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.data  = r;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(r);
		sent_cnt++;
	endtask

	// configure one side, raise some line events, then touch its data port and read back its control register
	task automatic run_sequence();
		logic       side;
		logic [1:0] ofs_data, ofs_ctl, line_one, line_two;
		logic [7:0] ctl;
		int         n_events;
		side     = 1'($urandom_range(0, 1));
		ofs_data = side ? ppa_pkg::OFS_DATA_B : ppa_pkg::OFS_DATA_A;
		ofs_ctl  = side ? ppa_pkg::OFS_CTRL_B : ppa_pkg::OFS_CTRL_A;
		line_one = side ? ppa_pkg::LINE_SEL_CB1 : ppa_pkg::LINE_SEL_CA1;
		line_two = side ? ppa_pkg::LINE_SEL_CB2 : ppa_pkg::LINE_SEL_CA2;
		if ($urandom_range(0, 2) == 0) begin
			ctl = 8'($urandom);
			ctl[ppa_pkg::BIT_SEL_OUT] = 1'b0;
			send_req(make_req(ppa_pkg::REQ_WRITE, ofs_ctl, ctl, 2'($urandom)));
			send_req(make_req(ppa_pkg::REQ_WRITE, ofs_data, 8'($urandom), 2'($urandom)));
		end
		send_req(make_req(ppa_pkg::REQ_WRITE, ofs_ctl, rand_ctl(), 2'($urandom)));
		n_events = $urandom_range(1, 4);
		repeat (n_events) begin
			send_req(make_req(ppa_pkg::REQ_EVENT, 2'($urandom), 8'($urandom),
				($urandom_range(0, 1) != 0) ? line_one : line_two));
			if ($urandom_range(0, 3) == 0)
				send_req(make_req(ppa_pkg::REQ_READ, ofs_ctl, 8'($urandom), 2'($urandom)));
		end
		case ($urandom_range(0, 2))
			0: send_req(make_req(ppa_pkg::REQ_READ, ofs_data, 8'($urandom), 2'($urandom)));
			1: send_req(make_req(ppa_pkg::REQ_WRITE, ofs_data, 8'($urandom), 2'($urandom)));
			default: begin
				send_req(make_req(ppa_pkg::REQ_READ, ofs_data, 8'($urandom), 2'($urandom)));
				send_req(make_req(ppa_pkg::REQ_WRITE, ofs_data, 8'($urandom), 2'($urandom)));
			end
		endcase
		send_req(make_req(ppa_pkg::REQ_READ, ofs_ctl, 8'($urandom), 2'($urandom)));
	endtask

	// result side: random stalls between beats
	initial begin
		rsp_ch.ready = 1'b0;
		rsp_calm = 0;
		@(posedge arst_n);
		forever begin
			int gap;
			gap = draw_gap(rsp_calm);
			repeat (gap) begin
				@(negedge clk);
				rsp_ch.ready = 1'b0;
			end
			@(negedge clk);
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			sb.check_result(rsp_ch.data);
		end
	end

	initial begin
		#5_000_000;
		$display("parallel_port_adapter regression: fail");
		$finish;
	end

	initial begin
		sb = new();
		sent_cnt = 0;
		req_calm = 0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values of the direction and control registers of both sides
		send_req(make_req(ppa_pkg::REQ_READ, ppa_pkg::OFS_DATA_A, 8'h00,
			ppa_pkg::LINE_SEL_CA1));
		send_req(make_req(ppa_pkg::REQ_READ, ppa_pkg::OFS_CTRL_A, 8'hFF,
			ppa_pkg::LINE_SEL_CA2));
		send_req(make_req(ppa_pkg::REQ_READ, ppa_pkg::OFS_DATA_B, 8'h00,
			ppa_pkg::LINE_SEL_CB1));
		send_req(make_req(ppa_pkg::REQ_READ, ppa_pkg::OFS_CTRL_B, 8'hFF,
			ppa_pkg::LINE_SEL_CB2));
		// side A: direction, then output masked by direction
		send_req(make_req(ppa_pkg::REQ_WRITE, ppa_pkg::OFS_DATA_A, 8'hF0,
			ppa_pkg::LINE_SEL_CA1));
		send_req(make_req(ppa_pkg::REQ_WRITE, ppa_pkg::OFS_CTRL_A, 8'h04,
			ppa_pkg::LINE_SEL_CA1));
		send_req(make_req(ppa_pkg::REQ_WRITE, ppa_pkg::OFS_DATA_A, 8'hFF,
			ppa_pkg::LINE_SEL_CA1));
		// CA2 read handshake with CA1 interrupt enabled
		send_req(make_req(ppa_pkg::REQ_WRITE, ppa_pkg::OFS_CTRL_A,
			ppa_pkg::MODE_HANDSHAKE | 8'h05, ppa_pkg::LINE_SEL_CA1));
		send_req(make_req(ppa_pkg::REQ_EVENT, ppa_pkg::OFS_DATA_A, 8'h00,
			ppa_pkg::LINE_SEL_CA1));
		send_req(make_req(ppa_pkg::REQ_READ, ppa_pkg::OFS_DATA_A, 8'h00,
			ppa_pkg::LINE_SEL_CA1));
		// manual output high then low
		send_req(make_req(ppa_pkg::REQ_WRITE, ppa_pkg::OFS_CTRL_A,
			ppa_pkg::MODE_MANUAL | 8'h0C, ppa_pkg::LINE_SEL_CA1));
		send_req(make_req(ppa_pkg::REQ_EVENT, ppa_pkg::OFS_DATA_A, 8'h00,
			ppa_pkg::LINE_SEL_CA2));
		send_req(make_req(ppa_pkg::REQ_WRITE, ppa_pkg::OFS_CTRL_A,
			ppa_pkg::MODE_MANUAL | 8'h04, ppa_pkg::LINE_SEL_CA1));
		// CA2 as interrupting input
		send_req(make_req(ppa_pkg::REQ_WRITE, ppa_pkg::OFS_CTRL_A, 8'h0D,
			ppa_pkg::LINE_SEL_CA1));
		send_req(make_req(ppa_pkg::REQ_EVENT, ppa_pkg::OFS_DATA_A, 8'h00,
			ppa_pkg::LINE_SEL_CA2));
		send_req(make_req(ppa_pkg::REQ_READ, ppa_pkg::OFS_CTRL_A, 8'h00,
			ppa_pkg::LINE_SEL_CA1));
		// side B: write handshake, a read leaves CB2 high
		send_req(make_req(ppa_pkg::REQ_WRITE, ppa_pkg::OFS_DATA_B, 8'hFF,
			ppa_pkg::LINE_SEL_CB1));
		send_req(make_req(ppa_pkg::REQ_WRITE, ppa_pkg::OFS_CTRL_B,
			ppa_pkg::MODE_HANDSHAKE | 8'h04, ppa_pkg::LINE_SEL_CB1));
		send_req(make_req(ppa_pkg::REQ_EVENT, ppa_pkg::OFS_DATA_B, 8'h00,
			ppa_pkg::LINE_SEL_CB1));
		send_req(make_req(ppa_pkg::REQ_READ, ppa_pkg::OFS_DATA_B, 8'h00,
			ppa_pkg::LINE_SEL_CB1));
		send_req(make_req(ppa_pkg::REQ_WRITE, ppa_pkg::OFS_DATA_B, 8'hFF,
			ppa_pkg::LINE_SEL_CB1));
		// CB2 in output mode never interrupts, in input mode it does
		send_req(make_req(ppa_pkg::REQ_WRITE, ppa_pkg::OFS_CTRL_B,
			ppa_pkg::MODE_MANUAL | 8'h0D, ppa_pkg::LINE_SEL_CB2));
		send_req(make_req(ppa_pkg::REQ_EVENT, ppa_pkg::OFS_DATA_B, 8'h00,
			ppa_pkg::LINE_SEL_CB2));
		send_req(make_req(ppa_pkg::REQ_WRITE, ppa_pkg::OFS_CTRL_B, 8'h09,
			ppa_pkg::LINE_SEL_CB2));
		send_req(make_req(ppa_pkg::REQ_EVENT, ppa_pkg::OFS_DATA_B, 8'h00,
			ppa_pkg::LINE_SEL_CB2));
		// full byte stored on a control write, flags included
		send_req(make_req(ppa_pkg::REQ_WRITE, ppa_pkg::OFS_CTRL_A, 8'hFF,
			ppa_pkg::LINE_SEL_CA1));
		send_req(make_req(ppa_pkg::REQ_READ, ppa_pkg::OFS_CTRL_A, 8'h00,
			ppa_pkg::LINE_SEL_CA1));
		// unused request code
		send_req(make_req(REQ_UNUSED, ppa_pkg::OFS_CTRL_B, 8'hFF, ppa_pkg::LINE_SEL_CB2));

		while (sent_cnt < NUM_ITEMS) begin
			if ($urandom_range(0, 9) < 7)
				run_sequence();
			else
				send_req(make_req(2'($urandom), 2'($urandom), 8'($urandom),
					2'($urandom)));
		end
		@(negedge clk);
		req_ch.valid = 1'b0;

		while (sb.expected_rsp.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatch_cnt == 0)
			$display("parallel_port_adapter regression: pass");
		else
			$display("parallel_port_adapter regression: fail");
		$finish;
	end

endmodule
